// ----- rtl/attractor_histogram_plotter_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the attractor histogram plotter
// Shared property forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef ATTRACTOR_HISTOGRAM_PLOTTER_ASSERT_SVH
`define ATTRACTOR_HISTOGRAM_PLOTTER_ASSERT_SVH

// Same-cycle implication, off while reset is asserted
`define AHP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ahp assertion failed");

// Next-cycle implication, off while reset is asserted
`define AHP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ahp assertion failed");

`endif

// ----- rtl/ahp_pkg.sv -----
// ---------------------------------------------------------------------------
// ahp_pkg
// Types, constants and the quarter-wave sine ROM of the attractor plotter.
// ---------------------------------------------------------------------------
package ahp_pkg;

    // Geometry
    localparam int MAX_SIDE   = 1024;
    localparam int COORD_W    = $clog2(MAX_SIDE);
    localparam int SIDE_W     = COORD_W + 1;
    localparam int STORE_AW   = 2 * COORD_W;
    localparam int IDX_W      = 20;
    localparam int PIX_W      = 20;
    localparam int SUM_W      = 50;

    // Phase table
    localparam int PHASE_BITS = 12;
    localparam int TABLE_SIZE = 1 << PHASE_BITS;
    localparam int QUARTER    = TABLE_SIZE / 4;
    localparam int QIDX_W     = PHASE_BITS - 1;
    localparam int ROM_W      = 15;
    localparam longint TWO_PI_Q32     = 64'sd26986075409;
    localparam longint INV_TWO_PI_Q32 = 64'sd683565276;
    localparam longint QSTEP_DIV      = 4 * TABLE_SIZE;

    // Input kinds
    localparam logic [1:0] KIND_ITERATE = 2'd0;
    localparam logic [1:0] KIND_READ    = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_COEF  = 3'd0;
    localparam logic [2:0] REG_SCOS  = 3'd1;
    localparam logic [2:0] REG_SSIN  = 3'd2;
    localparam logic [2:0] REG_XCTR  = 3'd3;
    localparam logic [2:0] REG_YCTR  = 3'd4;
    localparam logic [2:0] REG_WIDTH = 3'd5;
    localparam logic [2:0] REG_HGHT  = 3'd6;
    localparam logic [2:0] REG_WRAP  = 3'd7;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] blur_dx;
        logic signed [31:0] blur_dy;
        logic [19:0]        read_address;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
    } t_in;

    typedef struct packed {
        logic        plotted;
        logic [19:0] bucket_index;
        logic [31:0] bucket_count;
        logic [31:0] peak_count;
        logic [47:0] iteration_total;
    } t_out;

    typedef struct packed {
        logic [63:0]        coef;
        logic signed [31:0] scos;
        logic signed [31:0] ssin;
        logic signed [31:0] xctr;
        logic signed [31:0] yctr;
        logic [10:0]        width;
        logic [10:0]        height;
        logic               wrap;
    } t_cfg;

    typedef enum logic [1:0] {
        OP_ITER,
        OP_READ,
        OP_RESTART,
        OP_NOP
    } t_op;

    // Command handed from the front to the back
    typedef struct packed {
        t_op              op;
        logic             hit;
        logic [IDX_W-1:0] index;
    } t_cmd;

    typedef enum logic [3:0] {
        F_IDLE,
        F_MUL1,
        F_MUL2,
        F_ROM,
        F_NEW,
        F_PIX1,
        F_PIX2,
        F_PLACE,
        F_MOD,
        F_IDX,
        F_PUSH
    } t_fstate;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_UPD,
        B_RDOUT
    } t_bstate;

    typedef logic [ROM_W-1:0] t_qrom [0:QUARTER];

    // Next Taylor term before its factorial step: term * x * x in Q30
    function automatic longint unsigned taylor_mul(input longint term, input longint x);
        longint unsigned t;
        t = (longint'(term) * longint'(x)) >> 30;
        t = (t * longint'(x)) >> 30;
        return t;
    endfunction

    // Sine of k quarter-table steps, Q1.14, from a Q30 Taylor series
    function automatic logic [ROM_W-1:0] quarter_sine(input int k);
        longint x;
        longint term;
        longint sum;
        x    = (longint'(k) * TWO_PI_Q32) / QSTEP_DIV;
        term = x;
        sum  = x;
        term = longint'(taylor_mul(term, x) / 64'd6);
        sum  = sum - term;
        term = longint'(taylor_mul(term, x) / 64'd20);
        sum  = sum + term;
        term = longint'(taylor_mul(term, x) / 64'd42);
        sum  = sum - term;
        term = longint'(taylor_mul(term, x) / 64'd72);
        sum  = sum + term;
        term = longint'(taylor_mul(term, x) / 64'd110);
        sum  = sum - term;
        term = longint'(taylor_mul(term, x) / 64'd156);
        sum  = sum + term;
        term = longint'(taylor_mul(term, x) / 64'd210);
        sum  = sum - term;
        term = longint'(taylor_mul(term, x) / 64'd272);
        sum  = sum + term;
        term = longint'(taylor_mul(term, x) / 64'd342);
        sum  = sum - term;
        term = longint'(taylor_mul(term, x) / 64'd420);
        sum  = sum + term;
        if (sum < 0) begin
            sum = 0;
        end
        return ROM_W'((sum + 64'sd32768) >>> 16);
    endfunction

    function automatic t_qrom build_qrom();
        t_qrom rom;
        for (int k = 0; k <= QUARTER; k++) begin
            rom[k] = quarter_sine(k);
        end
        return rom;
    endfunction

    localparam t_qrom QROM = build_qrom();

endpackage

// ----- rtl/ahp_mod.sv -----
// ---------------------------------------------------------------------------
// ahp_mod
// Iterative signed remainder by the grid side, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module ahp_mod import ahp_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [PIX_W-1:0]  i_value,
    input  logic [SIDE_W-1:0]        i_side,
    output logic                     o_done,
    output logic [COORD_W-1:0]       o_rem
);

    localparam int CNT_W = $clog2(PIX_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [PIX_W-1:0]  r_mag;
    logic              r_neg;
    logic [COORD_W-1:0] r_rem;
    logic [SIDE_W-1:0] w_trial;
    logic [SIDE_W-1:0] w_fix;

    // Shift the next dividend bit into the partial remainder
    assign w_trial = {r_rem, r_mag[PIX_W-1]};

    // Control: busy flag and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(PIX_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: restoring remainder on the magnitude
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_value[PIX_W-1];
            r_mag <= i_value[PIX_W-1] ? PIX_W'(-i_value) : PIX_W'(i_value);
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= (w_trial >= i_side) ? COORD_W'(w_trial - i_side) : COORD_W'(w_trial);
            r_mag <= {r_mag[PIX_W-2:0], 1'b0};
        end
    end

    // Fold a negative value back into range
    assign w_fix  = i_side - SIDE_W'(r_rem);
    assign o_rem  = (r_neg && (r_rem != '0)) ? COORD_W'(w_fix) : r_rem;
    assign o_done = r_done;

endmodule

// ----- rtl/ahp_front.sv -----
// ---------------------------------------------------------------------------
// ahp_front
// Accepts items, runs the map and pixel mapping, queues commands to the back.
// ---------------------------------------------------------------------------
module ahp_front import ahp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_hold,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_in   i_in_data,
    input  logic  i_full,
    output logic  o_push,
    output t_cmd  o_cmd
);

    t_fstate r_state, n_state;

    logic signed [15:0]       r_orbit_x, r_orbit_y;
    logic signed [31:0]       r_blur_dx, r_blur_dy;
    logic signed [31:0]       r_prod [4];
    logic [PHASE_BITS-1:0]    r_phase [4];
    logic [PHASE_BITS-1:0]    w_phase [4];
    logic [2:0]               r_cnt;
    logic [ROM_W-1:0]         r_rom_q;
    logic                     r_rom_neg;
    logic signed [15:0]       w_rom_val;
    logic signed [15:0]       r_trig [4];
    logic [PHASE_BITS-1:0]    w_rom_p;
    logic [QIDX_W-1:0]        w_rom_idx;
    logic signed [16:0]       w_dx, w_dy;
    logic signed [47:0]       r_m [4];
    logic signed [SUM_W-1:0]  w_sum_x, w_sum_y;
    logic signed [32:0]       w_ox, w_oy;
    logic signed [PIX_W-1:0]  r_ix, r_iy;
    logic [SIDE_W-1:0]        w_w, w_h;
    logic                     w_in_x, w_in_y;
    logic [COORD_W-1:0]       r_col, r_row;
    logic                     r_hit;
    t_cmd                     r_cmd;
    logic                     w_accept;
    logic                     w_mod_start;
    logic                     w_done_x, w_done_y;
    logic [COORD_W-1:0]       w_rem_x, w_rem_y;

    // Grid sides clamped to 1..MAX_SIDE
    assign w_w = (i_cfg.width == '0) ? SIDE_W'(1) :
                 (i_cfg.width > 11'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : SIDE_W'(i_cfg.width);
    assign w_h = (i_cfg.height == '0) ? SIDE_W'(1) :
                 (i_cfg.height > 11'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : SIDE_W'(i_cfg.height);

    // Phase: angle times 1/(2 pi), rounded to one table step
    always_comb begin
        logic signed [63:0] turn;
        for (int i = 0; i < 4; i++) begin
            turn = 64'(r_prod[i]) * INV_TWO_PI_Q32 + (64'sd1 <<< (56 - PHASE_BITS));
            w_phase[i] = turn[56 -: PHASE_BITS];
        end
    end

    // Table address: sine of a and c phases, cosine of b and d phases
    always_comb begin
        case (r_cnt[1:0])
            2'd0:    w_rom_p = r_phase[0];
            2'd1:    w_rom_p = r_phase[1] + PHASE_BITS'(QUARTER);
            2'd2:    w_rom_p = r_phase[2];
            default: w_rom_p = r_phase[3] + PHASE_BITS'(QUARTER);
        endcase
        w_rom_idx = w_rom_p[PHASE_BITS-2] ?
                    QIDX_W'(QUARTER) - QIDX_W'(w_rom_p[PHASE_BITS-3:0]) :
                    QIDX_W'(w_rom_p[PHASE_BITS-3:0]);
    end

    // Quarter-wave ROM with registered read
    always_ff @(posedge i_clk) begin
        r_rom_q   <= QROM[w_rom_idx];
        r_rom_neg <= w_rom_p[PHASE_BITS-1];
    end

    assign w_rom_val = r_rom_neg ? -$signed(16'(r_rom_q)) : $signed(16'(r_rom_q));
    assign w_dx = 17'(r_trig[0]) - 17'(r_trig[1]);
    assign w_dy = 17'(r_trig[2]) - 17'(r_trig[3]);

    // Pixel sums before the floor
    assign w_ox    = 33'(i_cfg.xctr) + 33'(r_blur_dx);
    assign w_oy    = 33'(i_cfg.yctr) + 33'(r_blur_dy);
    assign w_sum_x = SUM_W'(r_m[0]) + SUM_W'(r_m[1]) + (SUM_W'(w_ox) <<< 13);
    assign w_sum_y = SUM_W'(r_m[3]) - SUM_W'(r_m[2]) + (SUM_W'(w_oy) <<< 13);

    assign w_in_x = !r_ix[PIX_W-1] && (r_ix < $signed({1'b0, PIX_W'(w_w)}));
    assign w_in_y = !r_iy[PIX_W-1] && (r_iy < $signed({1'b0, PIX_W'(w_h)}));

    // Wrap remainders for both axes
    ahp_mod u_mod_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mod_start),
        .i_value (r_ix),
        .i_side  (w_w),
        .o_done  (w_done_x),
        .o_rem   (w_rem_x)
    );

    ahp_mod u_mod_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mod_start),
        .i_value (r_iy),
        .i_side  (w_h),
        .o_done  (w_done_y),
        .o_rem   (w_rem_y)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (w_accept) begin
                    n_state = (i_in_data.kind == KIND_ITERATE) ? F_MUL1 : F_PUSH;
                end
            end
            F_MUL1:  n_state = F_MUL2;
            F_MUL2:  n_state = F_ROM;
            F_ROM:   n_state = (r_cnt == 3'd4) ? F_NEW : F_ROM;
            F_NEW:   n_state = F_PIX1;
            F_PIX1:  n_state = F_PIX2;
            F_PIX2:  n_state = F_PLACE;
            F_PLACE: n_state = i_cfg.wrap ? F_MOD : F_IDX;
            F_MOD:   n_state = (w_done_x && w_done_y) ? F_IDX : F_MOD;
            F_IDX:   n_state = F_PUSH;
            F_PUSH:  n_state = i_full ? F_PUSH : F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_stall  = (r_state != F_IDLE) || i_hold;
        w_accept    = i_in_valid && !o_in_stall;
        o_push      = (r_state == F_PUSH) && !i_full;
        w_mod_start = (r_state == F_PLACE) && i_cfg.wrap;
    end

    assign o_cmd = r_cmd;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= F_IDLE;
            r_orbit_x <= '0;
            r_orbit_y <= '0;
            r_cnt     <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept && (i_in_data.kind == KIND_RESTART)) begin
                r_orbit_x <= i_in_data.start_x;
                r_orbit_y <= i_in_data.start_y;
            end
            if (r_state == F_NEW) begin
                r_orbit_x <= 16'(w_dx >>> 1);
                r_orbit_y <= 16'(w_dy >>> 1);
            end
            if (r_state == F_ROM) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                r_blur_dx <= i_in_data.blur_dx;
                r_blur_dy <= i_in_data.blur_dy;
                r_cmd.hit <= 1'b0;
                case (i_in_data.kind)
                    KIND_ITERATE: begin
                        r_cmd.op    <= OP_ITER;
                        r_cmd.index <= '0;
                    end
                    KIND_READ: begin
                        r_cmd.op    <= OP_READ;
                        r_cmd.index <= i_in_data.read_address;
                    end
                    KIND_RESTART: begin
                        r_cmd.op    <= OP_RESTART;
                        r_cmd.index <= '0;
                    end
                    default: begin
                        r_cmd.op    <= OP_NOP;
                        r_cmd.index <= '0;
                    end
                endcase
            end
            F_MUL1: begin
                r_prod[0] <= $signed(i_cfg.coef[15:0])  * r_orbit_y;
                r_prod[1] <= $signed(i_cfg.coef[31:16]) * r_orbit_x;
                r_prod[2] <= $signed(i_cfg.coef[47:32]) * r_orbit_x;
                r_prod[3] <= $signed(i_cfg.coef[63:48]) * r_orbit_y;
            end
            F_MUL2: begin
                for (int i = 0; i < 4; i++) begin
                    r_phase[i] <= w_phase[i];
                end
            end
            F_ROM: begin
                if (r_cnt != 3'd0) begin
                    r_trig[2'(r_cnt - 3'd1)] <= w_rom_val;
                end
            end
            F_PIX1: begin
                r_m[0] <= i_cfg.scos * r_orbit_x;
                r_m[1] <= i_cfg.ssin * r_orbit_y;
                r_m[2] <= i_cfg.ssin * r_orbit_x;
                r_m[3] <= i_cfg.scos * r_orbit_y;
            end
            F_PIX2: begin
                r_ix <= PIX_W'(w_sum_x >>> 29);
                r_iy <= PIX_W'(w_sum_y >>> 29);
            end
            F_PLACE: begin
                r_hit <= w_in_x && w_in_y;
                r_col <= COORD_W'(r_ix);
                r_row <= COORD_W'(r_iy);
            end
            F_MOD: begin
                r_hit <= 1'b1;
                r_col <= w_rem_x;
                r_row <= w_rem_y;
            end
            F_IDX: begin
                r_cmd.hit   <= r_hit;
                r_cmd.index <= r_hit ?
                    (IDX_W'(r_col) + IDX_W'(w_w) * IDX_W'(r_row)) : '0;
            end
            default: begin
                r_cmd <= r_cmd;
            end
        endcase
    end

endmodule

// ----- rtl/ahp_fifo.sv -----
// ---------------------------------------------------------------------------
// ahp_fifo
// Two-entry command queue between the front and the back.
// ---------------------------------------------------------------------------
module ahp_fifo import ahp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_full,
    output logic o_empty
);

    t_cmd       r_slot [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    // Store the pushed beat
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_head  = r_slot[r_rd_ptr];
    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);

endmodule

// ----- rtl/ahp_back.sv -----
// ---------------------------------------------------------------------------
// ahp_back
// Histogram memory, clearing pass, peak and total, and the result register.
// ---------------------------------------------------------------------------
module ahp_back import ahp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_head,
    input  logic i_empty,
    output logic o_pop,
    output logic o_busy,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_bstate r_state, n_state;

    logic [31:0]         r_mem [1 << STORE_AW];
    logic [31:0]         r_mem_q;
    logic [STORE_AW-1:0] r_clr_addr;
    logic [31:0]         r_peak, n_peak;
    logic [47:0]         r_total, n_total;
    logic [47:0]         w_tot_inc;
    logic [31:0]         w_bump;
    t_cmd                r_cmd;
    t_out                r_out, n_out;
    logic                r_out_valid;
    logic                w_slot_free;
    logic                w_load;
    logic                w_we;
    logic [STORE_AW-1:0] w_waddr, w_raddr;
    logic [31:0]         w_wdata;
    logic                w_addr_ok;

    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_tot_inc   = (&r_total) ? r_total : r_total + 1'b1;
    assign w_bump      = (&r_mem_q) ? r_mem_q : r_mem_q + 1'b1;
    assign w_addr_ok   = (r_cmd.index >> STORE_AW) == '0;

    // Histogram memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_mem_q <= r_mem[w_raddr];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_CLEAR: n_state = (&r_clr_addr) ? B_IDLE : B_CLEAR;
            B_IDLE: begin
                if (o_pop) begin
                    case (i_head.op)
                        OP_ITER:    n_state = i_head.hit ? B_UPD : B_IDLE;
                        OP_READ:    n_state = B_RDOUT;
                        OP_RESTART: n_state = B_CLEAR;
                        default:    n_state = B_IDLE;
                    endcase
                end
            end
            B_UPD:   n_state = B_IDLE;
            B_RDOUT: n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // Outputs: memory port, pop and result beat
    always_comb begin
        o_pop   = 1'b0;
        w_we    = 1'b0;
        w_waddr = r_clr_addr;
        w_wdata = '0;
        w_raddr = i_head.index[STORE_AW-1:0];
        w_load  = 1'b0;
        n_peak  = r_peak;
        n_total = r_total;
        n_out   = '{plotted: 1'b0, bucket_index: '0, bucket_count: '0,
                   peak_count: r_peak, iteration_total: r_total};
        case (r_state)
            B_CLEAR: begin
                w_we = 1'b1;
            end
            B_IDLE: begin
                o_pop = !i_empty && w_slot_free;
                if (o_pop) begin
                    case (i_head.op)
                        OP_ITER: begin
                            if (!i_head.hit) begin
                                w_load  = 1'b1;
                                n_total = w_tot_inc;
                                n_out.iteration_total = w_tot_inc;
                            end
                        end
                        OP_READ: begin
                            w_load = 1'b0;
                        end
                        OP_RESTART: begin
                            w_load  = 1'b1;
                            n_peak  = '0;
                            n_total = '0;
                            n_out.peak_count      = '0;
                            n_out.iteration_total = '0;
                        end
                        default: begin
                            w_load = 1'b1;
                        end
                    endcase
                end
            end
            B_UPD: begin
                w_we    = 1'b1;
                w_waddr = r_cmd.index[STORE_AW-1:0];
                w_wdata = w_bump;
                w_load  = 1'b1;
                n_peak  = (w_bump > r_peak) ? w_bump : r_peak;
                n_total = w_tot_inc;
                n_out   = '{plotted: 1'b1, bucket_index: r_cmd.index,
                           bucket_count: w_bump, peak_count: n_peak,
                           iteration_total: w_tot_inc};
            end
            B_RDOUT: begin
                w_load = 1'b1;
                n_out.bucket_index = r_cmd.index;
                n_out.bucket_count = w_addr_ok ? r_mem_q : '0;
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
    end

    // Control and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr_addr  <= '0;
            r_peak      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_peak  <= n_peak;
            r_total <= n_total;
            if (r_state == B_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the popped command and the result beat
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_head;
        end
        if (w_load) begin
            r_out <= n_out;
        end
    end

    assign o_busy      = (r_state == B_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/attractor_histogram_plotter.sv -----
// ---------------------------------------------------------------------------
// attractor_histogram_plotter
// Density histogram of the de Jong attractor with wrap or clip placement.
// ---------------------------------------------------------------------------
// Input channel i_in_valid / o_in_stall / i_in_data carries one item per beat:
// iterate, read a bucket, or restart with a start point. Output channel
// o_out_valid / i_out_stall / o_out_data returns exactly one result per item.
// Configuration is written through i_cfg_wr_en / i_cfg_index / i_cfg_data;
// the user must write it only while the block is idle; the block does not enforce it.
// Items are handled one at a time by the front; the back runs behind it
// through a two-entry command queue and a result register.
// Each item passes through the front's states before it is queued: an iterate
// runs the map recurrence (multiply, phase multiply, four sine ROM reads), the
// pixel mapping and, when wrapping, the 20-step remainder unit; a read, restart
// or unused kind is queued directly. The front takes no new item until it has
// pushed the current one into the command queue.
// After reset, and after every restart, the back sweeps the 1,048,576-entry
// histogram memory one bucket per cycle; no item is accepted during the sweep.
// A stalled result holds in the output register; the front keeps going until
// the command queue fills, then stalls its input.
// ---------------------------------------------------------------------------
module attractor_histogram_plotter import ahp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    t_cfg r_cfg;
    t_cmd w_cmd, w_head;
    logic w_push, w_pop, w_full, w_empty, w_busy;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef   <= '0;
            r_cfg.scos   <= 32'sd65536;
            r_cfg.ssin   <= '0;
            r_cfg.xctr   <= '0;
            r_cfg.yctr   <= '0;
            r_cfg.width  <= 11'(MAX_SIDE);
            r_cfg.height <= 11'(MAX_SIDE);
            r_cfg.wrap   <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_COEF:  r_cfg.coef   <= i_cfg_data;
                REG_SCOS:  r_cfg.scos   <= i_cfg_data[31:0];
                REG_SSIN:  r_cfg.ssin   <= i_cfg_data[31:0];
                REG_XCTR:  r_cfg.xctr   <= i_cfg_data[31:0];
                REG_YCTR:  r_cfg.yctr   <= i_cfg_data[31:0];
                REG_WIDTH: r_cfg.width  <= i_cfg_data[10:0];
                REG_HGHT:  r_cfg.height <= i_cfg_data[10:0];
                REG_WRAP:  r_cfg.wrap   <= i_cfg_data[0];
                default:   r_cfg        <= r_cfg;
            endcase
        end
    end

    ahp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_hold     (w_busy),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_cmd      (w_cmd)
    );

    ahp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    ahp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_busy      (w_busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- rtl/ahp_checker.sv -----
// ---------------------------------------------------------------------------
// ahp_checker
// Port-level checks of the attractor histogram plotter, bound to the top.
// ---------------------------------------------------------------------------
`include "attractor_histogram_plotter_assert.svh"

module ahp_checker import ahp_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input t_out        o_out_data
);

    // Hold a stalled result beat
    `AHP_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

    // Reset empties the result register
    `AHP_ASSERT_NXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, !o_out_valid)

    // A plotted bucket is counted and bounded by the peak
    `AHP_ASSERT_IMP(a_plot_peak, i_clk, i_rst_n, o_out_valid && o_out_data.plotted, (o_out_data.bucket_count != 32'd0) && (o_out_data.peak_count >= o_out_data.bucket_count))

    // A plotted bucket comes from a counted iteration
    `AHP_ASSERT_IMP(a_plot_total, i_clk, i_rst_n, o_out_valid && o_out_data.plotted, o_out_data.iteration_total != 48'd0)

endmodule

bind attractor_histogram_plotter ahp_checker u_ahp_checker (.*);
